// ===== hw/rtl/vrrf_pkg.sv =====
// Package for the variable record ring FIFO.
// Holds command, status and register codes, default sizes and the result item type.
// No dependencies.
`timescale 1ns / 1ps

package vrrf_pkg;

   localparam int SlotsDefault        = 16;
   localparam int MaxSlotBytesDefault = 64;

   localparam int CmdWidth    = 2;
   localparam int ByteWidth   = 8;
   localparam int LenWidth    = 7;
   localparam int StatusWidth = 3;
   localparam int EntryWidth  = 5;
   localparam int CsrIdxWidth = 2;
   localparam int CsrDatWidth = 7;

   localparam int ResetSlotCount = 16;

   localparam logic [CmdWidth-1:0] CMD_PUSH   = 2'd0;
   localparam logic [CmdWidth-1:0] CMD_GET    = 2'd1;
   localparam logic [CmdWidth-1:0] CMD_REMOVE = 2'd2;
   localparam logic [CmdWidth-1:0] CMD_FLUSH  = 2'd3;

   localparam logic [StatusWidth-1:0] ST_OK        = 3'd0;
   localparam logic [StatusWidth-1:0] ST_FULL      = 3'd1;
   localparam logic [StatusWidth-1:0] ST_TOO_LONG  = 3'd2;
   localparam logic [StatusWidth-1:0] ST_EMPTY     = 3'd3;
   localparam logic [StatusWidth-1:0] ST_SMALL_BUF = 3'd4;

   localparam logic [CsrIdxWidth-1:0] REG_SLOT_COUNT = 2'd0;
   localparam logic [CsrIdxWidth-1:0] REG_SLOT_BYTES = 2'd1;

   typedef struct packed {
      logic [StatusWidth-1:0] status;
      logic [ByteWidth-1:0]   data_out;
      logic [LenWidth-1:0]    record_length;
      logic                   last_out;
      logic [EntryWidth-1:0]  entries;
      logic [EntryWidth-1:0]  peak_entries;
   } rsp_item_type;

endpackage

// ===== hw/rtl/vrrf_ram.sv =====
// Simple dual-port synchronous RAM, one write and one registered read port.
// Uses no package items.
`timescale 1ns / 1ps

module vrrf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== hw/rtl/vrrf_rsp_stage.sv =====
// Two-register result path: a staging register aligned with the payload RAM read,
// then the output register. Depends on vrrf_pkg.
`timescale 1ns / 1ps

module vrrf_rsp_stage
   import vrrf_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  rsp_item_type         item,
   input  logic                 from_mem,
   input  logic [ByteWidth-1:0] mem_rdata,
   output logic                 can_load,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_item_type         rsp_item
);

   logic         s1_valid_ff, s1_valid_in;
   rsp_item_type s1_item_ff, s1_item_in;
   logic         s1_mem_ff, s1_mem_in;
   logic         out_valid_ff, out_valid_in;
   rsp_item_type out_item_ff, out_item_in;
   rsp_item_type s1_view;
   logic         move;

   always_comb begin
      s1_view = s1_item_ff;
      s1_view.data_out = s1_mem_ff ? mem_rdata : '0;
      move = s1_valid_ff && (!out_valid_ff || rsp_ready);
      can_load = !s1_valid_ff || move;

      out_valid_in = out_valid_ff;
      out_item_in  = out_item_ff;
      if (move) begin
         out_valid_in = 1'b1;
         out_item_in  = s1_view;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end

      s1_valid_in = s1_valid_ff;
      s1_item_in  = s1_item_ff;
      s1_mem_in   = s1_mem_ff;
      if (load) begin
         s1_valid_in = 1'b1;
         s1_item_in  = item;
         s1_mem_in   = from_mem;
      end else if (move) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
      s1_item_ff  <= s1_item_in;
      s1_mem_ff   <= s1_mem_in;
      out_item_ff <= out_item_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

endmodule

// ===== hw/rtl/variable_record_ring_fifo.sv =====
// Variable record ring FIFO: fixed-size slots in a payload RAM, record lengths in a length RAM.
// Push, flush and failed requests: taken in ST_IDLE; result via staging and output registers.
// Get: in ST_GET, one byte per cycle from the payload RAM read port while can_load is high.
// Remove: passes through ST_REMOVE, which waits on the length RAM read of the new head.
// Synchronous active-high reset empties the queue, clears the peak and sets 16 slots / 64 bytes.
// Depends on vrrf_pkg, vrrf_ram, vrrf_rsp_stage.
`timescale 1ns / 1ps

module variable_record_ring_fifo
   import vrrf_pkg::*;
#(
   parameter int SLOTS          = SlotsDefault,
   parameter int MAX_SLOT_BYTES = MaxSlotBytesDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // data_in[7:0], buffer_size[14:8], remove_after[15]
   input  logic [15:0]            req_tdata,
   // cmd[1:0]
   input  logic [CmdWidth-1:0]    req_tuser,
   input  logic                   req_tlast,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // status[2:0], data_out[10:3], record_length[17:11], entries[22:18],
   // peak_entries[27:23], zero[31:28]
   output logic [31:0]            rsp_tdata,
   output logic                   rsp_tlast,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [CsrDatWidth-1:0] csr_wdata
);

   localparam int SW  = $clog2(SLOTS);
   localparam int CW  = $clog2(SLOTS + 1);
   localparam int OW  = $clog2(MAX_SLOT_BYTES + 1);
   localparam int PD  = SLOTS * MAX_SLOT_BYTES;
   localparam int PAW = $clog2(PD);
   localparam int ResetSlots = (ResetSlotCount < SLOTS) ? ResetSlotCount : SLOTS;

   typedef enum logic [1:0] {ST_IDLE, ST_GET, ST_REMOVE} state_type;

   state_type            state_ff, state_in;
   logic [SW-1:0]        head_ff, head_in, tail_ff, tail_in;
   logic [CW-1:0]        count_ff, count_in, peak_ff, peak_in;
   logic [OW-1:0]        woff_ff, woff_in;
   logic                 discard_ff, discard_in;
   logic [CW-1:0]        eff_slots_ff, eff_slots_in;
   logic [OW-1:0]        eff_bytes_ff, eff_bytes_in;
   logic [LenWidth-1:0]  head_len_ff, head_len_in;
   logic                 len_load_ff, len_load_in;
   logic [PAW-1:0]       rd_addr_ff, rd_addr_in;
   logic [LenWidth-1:0]  rd_left_ff, rd_left_in;
   logic [LenWidth-1:0]  get_len_ff, get_len_in;

   logic [CmdWidth-1:0]  cmd;
   logic [ByteWidth-1:0] data_in;
   logic [LenWidth-1:0]  buffer_size;
   logic                 remove_after;
   logic                 accept;

   logic                 s1_load, s1_mem, can_load;
   rsp_item_type         s1_item, rsp_item;

   logic                 pay_we, pay_re;
   logic [PAW-1:0]       pay_waddr, pay_raddr;
   logic [ByteWidth-1:0] pay_rdata;
   logic                 len_we;
   logic [LenWidth-1:0]  len_wdata, len_rdata;

   logic [CW-1:0]        head_inc, tail_inc;
   logic [SW-1:0]        head_next, tail_next;
   logic [OW-1:0]        woff_plus;
   logic [LenWidth-1:0]  glen;
   logic [StatusWidth-1:0] push_st;
   logic [4:0]           slots_raw;

   assign cmd          = req_tuser;
   assign data_in      = req_tdata[7:0];
   assign buffer_size  = req_tdata[14:8];
   assign remove_after = req_tdata[15];

   assign req_tready = (state_ff == ST_IDLE) && can_load;
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   always_comb begin
      head_inc  = CW'(head_ff) + CW'(1);
      tail_inc  = CW'(tail_ff) + CW'(1);
      head_next = (head_inc >= eff_slots_ff) ? '0 : SW'(head_inc);
      tail_next = (tail_inc >= eff_slots_ff) ? '0 : SW'(tail_inc);
      woff_plus = woff_ff + OW'(1);
      glen      = (int'(head_len_ff) > MAX_SLOT_BYTES) ? LenWidth'(MAX_SLOT_BYTES)
                                                        : head_len_ff;
      slots_raw = csr_wdata[4:0];

      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      peak_in      = peak_ff;
      woff_in      = woff_ff;
      discard_in   = discard_ff;
      eff_slots_in = eff_slots_ff;
      eff_bytes_in = eff_bytes_ff;
      head_len_in  = len_load_ff ? len_rdata : head_len_ff;
      len_load_in  = 1'b0;
      rd_addr_in   = rd_addr_ff;
      rd_left_in   = rd_left_ff;
      get_len_in   = get_len_ff;
      push_st      = ST_OK;

      s1_load = 1'b0;
      s1_mem  = 1'b0;
      s1_item = '0;
      s1_item.last_out = 1'b1;

      pay_we    = 1'b0;
      pay_waddr = PAW'(tail_ff) * PAW'(MAX_SLOT_BYTES) + PAW'(woff_ff);
      pay_re    = 1'b0;
      pay_raddr = rd_addr_ff;
      len_we    = 1'b0;
      len_wdata = LenWidth'(woff_plus);

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               s1_load = 1'b1;
               unique case (cmd)
                  CMD_PUSH: begin
                     if (count_ff >= eff_slots_ff) begin
                        push_st    = ST_FULL;
                        discard_in = !req_tlast;
                        woff_in    = '0;
                     end else if (discard_ff) begin
                        push_st = ST_TOO_LONG;
                        if (req_tlast) begin
                           discard_in = 1'b0;
                        end
                        woff_in = '0;
                     end else if (woff_ff >= eff_bytes_ff) begin
                        push_st    = ST_TOO_LONG;
                        discard_in = !req_tlast;
                        woff_in    = '0;
                     end else begin
                        pay_we = 1'b1;
                        if (req_tlast) begin
                           len_we   = 1'b1;
                           woff_in  = '0;
                           tail_in  = tail_next;
                           count_in = count_ff + CW'(1);
                           if (count_in > peak_ff) begin
                              peak_in = count_in;
                           end
                           if (count_ff == '0) begin
                              head_len_in = LenWidth'(woff_plus);
                           end
                        end else begin
                           woff_in = woff_plus;
                        end
                     end
                     s1_item.status        = push_st;
                     s1_item.record_length = (count_in == '0) ? '0 : head_len_in;
                  end
                  CMD_GET: begin
                     if (count_ff == '0) begin
                        s1_item.status = ST_EMPTY;
                     end else if (buffer_size < head_len_ff || head_len_ff == '0) begin
                        s1_item.status        = (head_len_ff == '0) ? ST_OK : ST_SMALL_BUF;
                        s1_item.record_length = head_len_ff;
                     end else begin
                        s1_load    = 1'b0;
                        state_in   = ST_GET;
                        rd_addr_in = PAW'(head_ff) * PAW'(MAX_SLOT_BYTES);
                        rd_left_in = glen;
                        get_len_in = glen;
                        if (remove_after) begin
                           head_in     = head_next;
                           count_in    = count_ff - CW'(1);
                           len_load_in = 1'b1;
                        end
                     end
                  end
                  CMD_REMOVE: begin
                     if (count_ff == '0) begin
                        s1_item.status = ST_EMPTY;
                     end else begin
                        s1_load     = 1'b0;
                        state_in    = ST_REMOVE;
                        head_in     = head_next;
                        count_in    = count_ff - CW'(1);
                        len_load_in = 1'b1;
                     end
                  end
                  CMD_FLUSH: begin
                     head_in    = '0;
                     tail_in    = '0;
                     count_in   = '0;
                     woff_in    = '0;
                     discard_in = 1'b0;
                  end
                  default: begin
                     s1_load = 1'b0;
                  end
               endcase
            end
         end
         ST_GET: begin
            if (can_load) begin
               pay_re  = 1'b1;
               s1_load = 1'b1;
               s1_mem  = 1'b1;
               s1_item.status        = ST_OK;
               s1_item.record_length = get_len_ff;
               s1_item.last_out      = (rd_left_ff == LenWidth'(1));
               rd_addr_in = rd_addr_ff + PAW'(1);
               rd_left_in = rd_left_ff - LenWidth'(1);
               if (rd_left_ff == LenWidth'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_REMOVE: begin
            s1_load = 1'b1;
            s1_item.status        = ST_OK;
            s1_item.record_length = (count_ff == '0) ? '0 : len_rdata;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      s1_item.entries      = EntryWidth'(count_in);
      s1_item.peak_entries = EntryWidth'(peak_in);

      if (csr_valid) begin
         if (csr_index == REG_SLOT_COUNT || csr_index == REG_SLOT_BYTES) begin
            head_in    = '0;
            tail_in    = '0;
            count_in   = '0;
            woff_in    = '0;
            discard_in = 1'b0;
         end
         if (csr_index == REG_SLOT_COUNT) begin
            if (slots_raw == '0) begin
               eff_slots_in = CW'(1);
            end else if (int'(slots_raw) > SLOTS) begin
               eff_slots_in = CW'(SLOTS);
            end else begin
               eff_slots_in = CW'(slots_raw);
            end
         end
         if (csr_index == REG_SLOT_BYTES) begin
            if (csr_wdata == '0) begin
               eff_bytes_in = OW'(1);
            end else if (int'(csr_wdata) > MAX_SLOT_BYTES) begin
               eff_bytes_in = OW'(MAX_SLOT_BYTES);
            end else begin
               eff_bytes_in = OW'(csr_wdata);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         peak_ff      <= '0;
         woff_ff      <= '0;
         discard_ff   <= 1'b0;
         eff_slots_ff <= CW'(ResetSlots);
         eff_bytes_ff <= OW'(MAX_SLOT_BYTES);
         len_load_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         peak_ff      <= peak_in;
         woff_ff      <= woff_in;
         discard_ff   <= discard_in;
         eff_slots_ff <= eff_slots_in;
         eff_bytes_ff <= eff_bytes_in;
         len_load_ff  <= len_load_in;
      end
      head_len_ff <= head_len_in;
      rd_addr_ff  <= rd_addr_in;
      rd_left_ff  <= rd_left_in;
      get_len_ff  <= get_len_in;
   end

   vrrf_ram #(
      .WIDTH (ByteWidth),
      .DEPTH (PD)
   ) u_payload_ram (
      .clock (clock),
      .we    (pay_we),
      .waddr (pay_waddr),
      .wdata (data_in),
      .re    (pay_re),
      .raddr (pay_raddr),
      .rdata (pay_rdata)
   );

   vrrf_ram #(
      .WIDTH (LenWidth),
      .DEPTH (SLOTS)
   ) u_length_ram (
      .clock (clock),
      .we    (len_we),
      .waddr (tail_ff),
      .wdata (len_wdata),
      .re    (1'b1),
      .raddr (head_in),
      .rdata (len_rdata)
   );

   vrrf_rsp_stage u_rsp_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (s1_load),
      .item      (s1_item),
      .from_mem  (s1_mem),
      .mem_rdata (pay_rdata),
      .can_load  (can_load),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_item  (rsp_item)
   );

   assign rsp_tdata = {4'b0, rsp_item.peak_entries, rsp_item.entries,
                       rsp_item.record_length, rsp_item.data_out, rsp_item.status};
   assign rsp_tlast = rsp_item.last_out;

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the variable record ring FIFO: a scoreboard class predicts every
// response from the accepted requests and register writes; plain tasks drive the stream ports.
// Depends on vrrf_pkg and variable_record_ring_fifo.
`timescale 1ns / 1ps

module testbench
   import vrrf_pkg::*;
();

   localparam int SLOTS     = SlotsDefault;
   localparam int MAX_BYTES = MaxSlotBytesDefault;
   localparam int PHASES    = 9;
   localparam int PHASE_REQUESTS = 40;
   localparam logic [CsrIdxWidth-1:0] REG_NONE = 2'd2;

   class record_fifo_scoreboard;
      bit [7:0] payload [SLOTS*MAX_BYTES];
      bit [6:0] lengths [SLOTS];
      int unsigned head, tail, held, peak, write_offset;
      bit discarding;
      int unsigned slot_count, slot_bytes;
      rsp_item_type expected_rsp_q[$];
      int errors;

      function new();
         head = 0;
         tail = 0;
         held = 0;
         peak = 0;
         write_offset = 0;
         discarding = 0;
         slot_count = ResetSlotCount;
         slot_bytes = MAX_BYTES;
         errors = 0;
      endfunction

      function int unsigned usable_slots();
         if (slot_count < 1) return 1;
         if (slot_count > SLOTS) return SLOTS;
         return slot_count;
      endfunction

      function int unsigned usable_bytes();
         if (slot_bytes < 1) return 1;
         if (slot_bytes > MAX_BYTES) return MAX_BYTES;
         return slot_bytes;
      endfunction

      function void clear_queue();
         head = 0;
         tail = 0;
         held = 0;
         write_offset = 0;
         discarding = 0;
      endfunction

      function int unsigned head_length();
         if (held == 0) return 0;
         return 32'(lengths[head % SLOTS]);
      endfunction

      function void pop_head();
         if (held == 0) return;
         head = (head + 1 >= usable_slots()) ? 0 : head + 1;
         held--;
      endfunction

      function void emit(logic [2:0] st, logic [7:0] dout, int unsigned len, bit last);
         rsp_item_type item;
         item.status        = st;
         item.data_out      = dout;
         item.record_length = len[6:0];
         item.last_out      = last;
         item.entries       = held[4:0];
         item.peak_entries  = peak[4:0];
         expected_rsp_q.push_back(item);
      endfunction

      function void note_config(logic [CsrIdxWidth-1:0] idx, logic [CsrDatWidth-1:0] val);
         if (idx == REG_SLOT_COUNT) begin
            slot_count = 32'(val[4:0]);
            clear_queue();
         end else if (idx == REG_SLOT_BYTES) begin
            slot_bytes = 32'(val);
            clear_queue();
         end
      endfunction

      function logic [2:0] push_byte(logic [7:0] din, logic last);
         int unsigned t;
         if (held >= usable_slots()) begin
            discarding = !last;
            write_offset = 0;
            return ST_FULL;
         end
         if (discarding) begin
            if (last) discarding = 0;
            write_offset = 0;
            return ST_TOO_LONG;
         end
         if (write_offset >= usable_bytes()) begin
            discarding = !last;
            write_offset = 0;
            return ST_TOO_LONG;
         end
         t = tail % SLOTS;
         payload[t*MAX_BYTES + write_offset % MAX_BYTES] = din;
         write_offset++;
         if (last) begin
            lengths[t] = write_offset[6:0];
            write_offset = 0;
            tail = (tail + 1 >= usable_slots()) ? 0 : tail + 1;
            held++;
            if (held > peak) peak = held;
         end
         return ST_OK;
      endfunction

      function void note_request(logic [1:0] cmd, logic [7:0] din, logic last,
                                 logic [6:0] bsz, logic rem);
         int unsigned len, base;
         logic [2:0] st;
         case (cmd)
            CMD_PUSH: begin
               st = push_byte(din, last);
               emit(st, 8'd0, head_length(), 1'b1);
            end
            CMD_GET: begin
               if (held == 0) begin
                  emit(ST_EMPTY, 8'd0, 0, 1'b1);
               end else begin
                  len = head_length();
                  if (bsz < len || len == 0) begin
                     emit((len == 0) ? ST_OK : ST_SMALL_BUF, 8'd0, len, 1'b1);
                  end else begin
                     if (len > MAX_BYTES) len = MAX_BYTES;
                     base = (head % SLOTS) * MAX_BYTES;
                     if (rem) pop_head();
                     for (int i = 0; i < len; i++)
                        emit(ST_OK, payload[base + i], len, (i + 1 == len));
                  end
               end
            end
            CMD_REMOVE: begin
               st = (held == 0) ? ST_EMPTY : ST_OK;
               pop_head();
               emit(st, 8'd0, head_length(), 1'b1);
            end
            default: begin
               clear_queue();
               emit(ST_OK, 8'd0, 0, 1'b1);
            end
         endcase
      endfunction

      function void compare(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            errors++;
         end
      endfunction

      function void check_result(logic [31:0] tdata, logic tlast);
         rsp_item_type want;
         if (expected_rsp_q.size() == 0) begin
            $error("unexpected response: tdata %h, tlast %b", tdata, tlast);
            errors++;
            return;
         end
         want = expected_rsp_q.pop_front();
         compare("status", 32'(want.status), 32'(tdata[2:0]));
         compare("data_out", 32'(want.data_out), 32'(tdata[10:3]));
         compare("record_length", 32'(want.record_length), 32'(tdata[17:11]));
         compare("last_out", 32'(want.last_out), 32'(tlast));
         compare("entries", 32'(want.entries), 32'(tdata[22:18]));
         compare("peak_entries", 32'(want.peak_entries), 32'(tdata[27:23]));
         compare("zero pad", 32'd0, 32'(tdata[31:28]));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [15:0] req_tdata = '0;
   logic [CmdWidth-1:0] req_tuser = CMD_PUSH;
   logic req_tlast = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic rsp_tlast;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CsrIdxWidth-1:0] csr_index = REG_SLOT_COUNT;
   logic [CsrDatWidth-1:0] csr_wdata = '0;

   record_fifo_scoreboard board;
   int req_gap_pct = 10;
   int rsp_stall_pct = 72;
   int phase_sent;

   int phase_slots [PHASES] = '{16, 1, 31, 4, 96, 2, 7, 127, 9};
   int phase_bytes [PHASES] = '{64, 1, 127, 8, 0, 3, 64, 5, 16};

   variable_record_ring_fifo dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_result(rsp_tdata, rsp_tlast);
   end

   task automatic send_req(logic [1:0] cmd, logic [7:0] din, logic last,
                           logic [6:0] bsz, logic rem);
      while ($urandom_range(0, 99) < req_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {rem, bsz, din};
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_request(cmd, din, last, bsz, rem);
      phase_sent++;
   endtask

   task automatic push_record(int len, bit terminate);
      for (int i = 0; i < len; i++)
         send_req(CMD_PUSH, 8'($urandom), terminate && (i == len - 1),
                  7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
   endtask

   task automatic get_head(logic [6:0] bsz, logic rem);
      send_req(CMD_GET, 8'($urandom), 1'($urandom_range(0, 1)), bsz, rem);
   endtask

   task automatic wait_drained(int settle);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (board.expected_rsp_q.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_csr(logic [CsrIdxWidth-1:0] idx, logic [CsrDatWidth-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.note_config(idx, val);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic int pick_record_length();
      int sb;
      int r;
      sb = board.usable_bytes();
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, (sb < 6) ? sb : 6);
      if (r < 90) return $urandom_range(1, sb);
      return sb + $urandom_range(1, 3);
   endfunction

   task automatic random_request();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) begin
         push_record(pick_record_length(), $urandom_range(0, 19) != 0);
      end else if (r < 75) begin
         get_head(7'(($urandom_range(0, 9) < 7) ? $urandom_range(64, 127)
                                                : $urandom_range(0, 127)),
                  $urandom_range(0, 9) < 8);
      end else if (r < 88) begin
         send_req(CMD_REMOVE, 8'($urandom), 1'($urandom_range(0, 1)),
                  7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
      end else if (r < 92) begin
         send_req(CMD_FLUSH, 8'($urandom), 1'($urandom_range(0, 1)),
                  7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
      end else begin
         send_req(2'($urandom_range(0, 3)), 8'($urandom), 1'($urandom_range(0, 1)),
                  7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
      end
   endtask

   initial begin
      bit paused;
      board = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // default sizes: extremes of data and buffer size, every command, empty queue
      send_req(CMD_PUSH, 8'h00, 1'b1, 7'd0, 1'b0);
      send_req(CMD_PUSH, 8'hFF, 1'b0, 7'd127, 1'b1);
      send_req(CMD_PUSH, 8'hA5, 1'b0, 7'd0, 1'b0);
      send_req(CMD_PUSH, 8'h5A, 1'b1, 7'd64, 1'b1);
      get_head(7'd0, 1'b1);
      get_head(7'd127, 1'b0);
      get_head(7'd1, 1'b1);
      get_head(7'd2, 1'b0);
      send_req(CMD_REMOVE, 8'hFF, 1'b1, 7'd127, 1'b1);
      send_req(CMD_REMOVE, 8'h00, 1'b0, 7'd0, 1'b0);
      get_head(7'd64, 1'b1);
      send_req(CMD_PUSH, 8'h81, 1'b0, 7'd0, 1'b0);
      send_req(CMD_PUSH, 8'h7E, 1'b0, 7'd0, 1'b0);
      send_req(CMD_FLUSH, 8'h00, 1'b0, 7'd0, 1'b0);
      send_req(CMD_FLUSH, 8'hFF, 1'b1, 7'd127, 1'b1);
      wait_drained(8);

      // one slot of two bytes: record too long, queue full, discard through last byte
      write_csr(REG_SLOT_BYTES, 7'd2);
      write_csr(REG_SLOT_COUNT, 7'd1);
      push_record(3, 1'b1);
      push_record(2, 1'b1);
      push_record(2, 1'b1);
      get_head(7'd1, 1'b1);
      get_head(7'd2, 1'b1);
      send_req(CMD_REMOVE, 8'h00, 1'b0, 7'd0, 1'b0);
      wait_drained(8);

      for (int p = 0; p < PHASES; p++) begin
         case (p / 3)
            0: begin
               req_gap_pct = 10;
               rsp_stall_pct = 72;
            end
            1: begin
               req_gap_pct = 72;
               rsp_stall_pct = 10;
            end
            default: begin
               req_gap_pct = 0;
               rsp_stall_pct = 0;
            end
         endcase
         write_csr(REG_SLOT_COUNT, CsrDatWidth'(phase_slots[p]));
         write_csr(REG_SLOT_BYTES, CsrDatWidth'(phase_bytes[p]));
         if (p == 3) write_csr(REG_NONE, 7'd5);
         phase_sent = 0;
         paused = 0;
         while (phase_sent < PHASE_REQUESTS) begin
            random_request();
            if (!paused && phase_sent >= PHASE_REQUESTS / 2) begin
               paused = 1;
               if (p == 0 || $urandom_range(0, 3) == 0) wait_drained(0);
            end
         end
         wait_drained(8);
      end

      wait_drained(20);
      if (board.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #8_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
